@@ sv/lpmd_pkg.sv @@
// Shared types and constants for the length-prefixed message deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lpmd_pkg;

    localparam int HDR_BYTES = 10;
    localparam int MAX_PAYLOAD_W = 18;
    localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 18'h3FFFF;
    localparam int OUT_DEPTH = 3;

    // input kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_LEN_ERR = 2'd2;
    localparam logic [1:0] ST_DROP = 2'd3;

    // register indexes
    localparam logic REG_MAX_PAYLOAD = 1'b0;

    localparam logic [3:0] CNT_PAYLOAD = 4'd10;

    typedef struct packed {
        logic [3:0] count;
        logic [15:0] mtype;
        logic [31:0] tag;
        logic [31:0] remaining;
    } entry_t;

    typedef struct packed {
        logic [7:0] slot;
        logic [7:0] payload_byte;
        logic [15:0] message_type;
        logic [31:0] message_tag;
        logic [1:0] status;
        logic last;
    } result_t;

endpackage

@@ sv/lpmd_state_mem.sv @@
// Per-slot deframer state memory: one write port, one read port, registered read.
// Depends on lpmd_pkg for the entry layout.
`timescale 1ns / 1ps

module lpmd_state_mem
    import lpmd_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int ADDR_W = 8
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/lpmd_step.sv @@
// Next-state and result logic for one stream byte or close event on one slot.
// Depends on lpmd_pkg for entry and result layouts and the status codes.
`timescale 1ns / 1ps

module lpmd_step
    import lpmd_pkg::*;
(
    input  entry_t                   cur,
    input  logic                     kind,
    input  logic [7:0]               slot,
    input  logic [7:0]               data_byte,
    input  logic [MAX_PAYLOAD_W-1:0] max_payload,
    output entry_t                   nxt,
    output logic                     res_valid,
    output result_t                  res
);

    logic [31:0] total;
    logic [31:0] pay;
    logic [31:0] rem;
    logic        fin;

    always_comb
    begin
        nxt = cur;
        res_valid = 1'b0;
        res.slot = slot;
        res.payload_byte = 8'd0;
        res.message_type = 16'd0;
        res.message_tag = 32'd0;
        res.status = ST_PAYLOAD;
        res.last = 1'b1;
        total = cur.remaining;
        pay = total - 32'(HDR_BYTES);
        rem = cur.remaining;
        fin = 1'b0;

        if (kind == KIND_CLOSE)
        begin
            // drop any partial frame; header fields only once the header is complete
            nxt.count = 4'd0;
            res_valid = (cur.count != 4'd0);
            res.status = ST_DROP;
            if (cur.count >= CNT_PAYLOAD)
            begin
                res.message_type = cur.mtype;
                res.message_tag = cur.tag;
            end
        end
        else if (cur.count < CNT_PAYLOAD)
        begin
            nxt.count = cur.count + 4'd1;
            case (cur.count)
                4'd0: nxt.mtype = {8'd0, data_byte};
                4'd1: nxt.mtype[15:8] = data_byte;
                4'd2: nxt.remaining = {24'd0, data_byte};
                4'd3: nxt.remaining[15:8] = data_byte;
                4'd4: nxt.remaining[23:16] = data_byte;
                4'd5: nxt.remaining[31:24] = data_byte;
                4'd6: nxt.tag = {24'd0, data_byte};
                4'd7: nxt.tag[15:8] = data_byte;
                4'd8: nxt.tag[23:16] = data_byte;
                default: nxt.tag[31:24] = data_byte;
            endcase

            if (cur.count == 4'd9)
            begin
                res.message_type = nxt.mtype;
                res.message_tag = nxt.tag;
                if (total < 32'(HDR_BYTES) || pay > {14'd0, max_payload})
                begin
                    nxt.count = 4'd0;
                    res_valid = 1'b1;
                    res.status = ST_LEN_ERR;
                end
                else if (pay == 32'd0)
                begin
                    nxt.count = 4'd0;
                    res_valid = 1'b1;
                    res.status = ST_EMPTY;
                end
                else
                begin
                    nxt.remaining = pay;
                    nxt.count = CNT_PAYLOAD;
                end
            end
        end
        else
        begin
            if (rem != 32'd0)
            begin
                rem = rem - 32'd1;
            end
            fin = (rem == 32'd0);
            nxt.remaining = rem;
            nxt.count = fin ? 4'd0 : CNT_PAYLOAD;
            res_valid = 1'b1;
            res.payload_byte = data_byte;
            res.message_type = cur.mtype;
            res.message_tag = cur.tag;
            res.status = ST_PAYLOAD;
            res.last = fin;
        end
    end

endmodule

@@ sv/lpmd_out_fifo.sv @@
// Three-entry result queue that decouples the state update from output stalls.
// Depends on lpmd_pkg for the result layout and depth.
`timescale 1ns / 1ps

module lpmd_out_fifo
    import lpmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  result_t     wr_result,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_data,
    output logic [1:0]  level
);

    result_t     buf_mem [OUT_DEPTH];
    logic [1:0]  wr_ptr_reg;
    logic [1:0]  wr_ptr_next;
    logic [1:0]  rd_ptr_reg;
    logic [1:0]  rd_ptr_next;
    logic [1:0]  level_reg;
    logic [1:0]  level_next;
    logic        pop;

    assign pop = out_valid && out_ready;
    assign out_valid = (level_reg != 2'd0);
    assign out_data = buf_mem[rd_ptr_reg];
    assign level = level_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == 2'(OUT_DEPTH - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == 2'(OUT_DEPTH - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            level_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= wr_result;
        end
    end

endmodule

@@ sv/length_prefixed_message_deframer.sv @@
// Length-prefixed message deframer: takes one byte or close event per cycle while
// input ready is high and keeps each connection's header and length state in a
// single-port-read state memory. A request is read from memory on acceptance and
// updated and written back the next cycle, when any result it gives is queued; a
// back-to-back request to the same slot takes the just-written entry through a
// forwarding register, giving a sustained rate of one request per cycle while input
// ready is high. After reset the block runs a clearing pass over all CONNECTIONS
// entries, one per cycle, during which no request is taken (configuration writes are).
// A three-entry result queue absorbs output stalls; input ready is low in the clearing
// pass and when the queue's results plus any request in the update stage reach three.
// Depends on lpmd_pkg, lpmd_state_mem, lpmd_step and lpmd_out_fifo.
`timescale 1ns / 1ps

module length_prefixed_message_deframer
    import lpmd_pkg::*;
#(
    parameter int CONNECTIONS = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         kind,
    input  logic [7:0]   connection,
    input  logic [7:0]   data_byte,
    // result stream
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   slot,
    output logic [7:0]   payload_byte,
    output logic [15:0]  message_type,
    output logic [31:0]  message_tag,
    output logic [1:0]   status,
    output logic         last
);

    localparam int IDX_W = $clog2(CONNECTIONS);
    localparam logic [16:0] CONN_LIMIT = 17'(CONNECTIONS);

    logic [MAX_PAYLOAD_W-1:0] max_payload_reg;
    logic                     cfg_write;

    logic                     clr_reg;
    logic [IDX_W-1:0]         clr_idx_reg;

    logic                     accept;
    logic [16:0]              conn_wide;
    logic [IDX_W-1:0]         in_idx;
    logic                     in_range;

    logic                     s1_valid_reg;
    logic                     s1_kind_reg;
    logic [7:0]               s1_conn_reg;
    logic [7:0]               s1_byte_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic                     s1_range_reg;
    logic                     fwd_hit_reg;
    entry_t                   fwd_entry_reg;

    entry_t                   rd_entry;
    entry_t                   cur_entry;
    entry_t                   nxt_entry;
    logic                     res_valid;
    result_t                  res;
    logic                     s1_we;

    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    entry_t                   mem_wdata;

    logic                     push;
    result_t                  out_data;
    logic [1:0]               level;
    logic [2:0]               occupancy;

    // configuration port
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {14'd0, max_payload_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_write && paddr[2] == REG_MAX_PAYLOAD)
        begin
            max_payload_reg <= pwdata[MAX_PAYLOAD_W-1:0];
        end
    end

    // input side
    assign conn_wide = {9'd0, connection};
    assign in_range = (conn_wide < CONN_LIMIT);
    assign in_idx = conn_wide[IDX_W-1:0];
    assign occupancy = {1'b0, level} + {2'd0, s1_valid_reg};
    assign in_ready = !clr_reg && (occupancy < 3'(OUT_DEPTH));
    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= 1'b1;
            clr_idx_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(CONNECTIONS - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
            s1_valid_reg <= accept;
            // forward when the entry being written is the one just read
            fwd_hit_reg <= accept && s1_we && (s1_idx_reg == in_idx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg <= kind;
            s1_conn_reg <= connection;
            s1_byte_reg <= data_byte;
            s1_idx_reg <= in_idx;
            s1_range_reg <= in_range;
        end
        fwd_entry_reg <= nxt_entry;
    end

    lpmd_state_mem #(
        .DEPTH  (CONNECTIONS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (in_idx),
        .rdata (rd_entry)
    );

    assign cur_entry = fwd_hit_reg ? fwd_entry_reg : rd_entry;

    lpmd_step u_step (
        .cur         (cur_entry),
        .kind        (s1_kind_reg),
        .slot        (s1_conn_reg),
        .data_byte   (s1_byte_reg),
        .max_payload (max_payload_reg),
        .nxt         (nxt_entry),
        .res_valid   (res_valid),
        .res         (res)
    );

    assign s1_we = s1_valid_reg && s1_range_reg;
    assign mem_we = clr_reg || s1_we;
    assign mem_waddr = clr_reg ? clr_idx_reg : s1_idx_reg;
    assign mem_wdata = clr_reg ? entry_t'('0) : nxt_entry;
    assign push = s1_we && res_valid;

    lpmd_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_result (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .level     (level)
    );

    assign slot = out_data.slot;
    assign payload_byte = out_data.payload_byte;
    assign message_type = out_data.message_type;
    assign message_tag = out_data.message_tag;
    assign status = out_data.status;
    assign last = out_data.last;

    // result queue never overflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= 3'(OUT_DEPTH))
        else $error("result queue overflow");

    // no request taken while the state memory is being cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !in_ready)
        else $error("request accepted during clearing pass");

    // a forwarded entry always comes from a write in the previous cycle
    a_fwd_source: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> $past(s1_we) && s1_valid_reg)
        else $error("forwarding without a preceding write");

    // written state never goes past the payload count
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_we |-> nxt_entry.count <= CNT_PAYLOAD)
        else $error("header count out of range");

endmodule

@@ test/tb_length_prefixed_message_deframer.sv @@
// Testbench for length_prefixed_message_deframer: interleaved frames on random slots,
// with closes, bad lengths and stray bytes, checked result by result against a predictor.
// Depends on lpmd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_length_prefixed_message_deframer;
    import lpmd_pkg::*;

    localparam int CONNECTIONS = 256;
    localparam int CYCLE_LIMIT = 500000;
    localparam int QUIET_CYCLES = 8;
    localparam int STREAMS = 4;
    localparam int MAX_FRAME_PAYLOAD = 14;
    localparam int UNUSED_REG = 1;
    localparam logic [2:0] MAX_PAYLOAD_ADDR = {REG_MAX_PAYLOAD, 2'b00};
    localparam logic [2:0] UNUSED_ADDR = 3'(UNUSED_REG * 4);

    logic        clk;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = KIND_DATA;
    logic [7:0]  connection = '0;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  slot;
    logic [7:0]  payload_byte;
    logic [15:0] message_type;
    logic [31:0] message_tag;
    logic [1:0]  status;
    logic        last;

    // predictor state, one entry per connection slot
    logic [MAX_PAYLOAD_W-1:0] payload_limit = MAX_PAYLOAD_RESET;
    logic [3:0]  hdr_count [CONNECTIONS];
    logic [15:0] hdr_type [CONNECTIONS];
    logic [31:0] hdr_tag [CONNECTIONS];
    logic [31:0] frame_len [CONNECTIONS];
    result_t     expected_results [$];

    // frames in flight, interleaved by the random traffic
    int          stream_slot [STREAMS];
    int          stream_pos [STREAMS];
    int          stream_len [STREAMS];
    logic [7:0]  stream_buf [STREAMS][HDR_BYTES + MAX_FRAME_PAYLOAD];

    bit tx_gaps_on = 1'b0;
    bit rx_stalls_on = 1'b0;
    int hold_off_request = 0;
    int error_count = 0;
    int results_checked = 0;
    int requests_sent = 0;
    int frames_started = 0;
    int limit_settings = 0;
    int cycle_count = 0;

    length_prefixed_message_deframer #(.CONNECTIONS(CONNECTIONS)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .connection(connection),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .slot(slot),
        .payload_byte(payload_byte),
        .message_type(message_type),
        .message_tag(message_tag),
        .status(status),
        .last(last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timed out with %0d results outstanding", expected_results.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic int random_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Advance one slot's deframer by one request and queue the result it gives.
    task automatic deframe_request(input logic k, input logic [7:0] c, input logic [7:0] b);
        result_t     r;
        logic [3:0]  n;
        logic [31:0] total;
        logic [31:0] rem;
        n = hdr_count[c];
        r = '0;
        r.slot = c;
        r.last = 1'b1;
        if (k == KIND_CLOSE)
        begin
            hdr_count[c] = '0;
            if (n != 0)
            begin
                r.status = ST_DROP;
                if (n >= HDR_BYTES)
                begin
                    r.message_type = hdr_type[c];
                    r.message_tag = hdr_tag[c];
                end
                expected_results.push_back(r);
            end
        end
        else if (n < HDR_BYTES)
        begin
            case (n)
                0: hdr_type[c] = {8'h00, b};
                1: hdr_type[c][15:8] = b;
                2: frame_len[c] = {24'h0, b};
                3, 4, 5: frame_len[c][8 * (n - 2) +: 8] = b;
                6: hdr_tag[c] = {24'h0, b};
                default: hdr_tag[c][8 * (n - 6) +: 8] = b;
            endcase
            n++;
            if (n < HDR_BYTES)
                hdr_count[c] = n;
            else
            begin
                total = frame_len[c];
                r.message_type = hdr_type[c];
                r.message_tag = hdr_tag[c];
                if (total < 32'(HDR_BYTES) || total - 32'(HDR_BYTES) > 32'(payload_limit))
                begin
                    hdr_count[c] = '0;
                    r.status = ST_LEN_ERR;
                    expected_results.push_back(r);
                end
                else if (total == 32'(HDR_BYTES))
                begin
                    hdr_count[c] = '0;
                    r.status = ST_EMPTY;
                    expected_results.push_back(r);
                end
                else
                begin
                    frame_len[c] = total - 32'(HDR_BYTES);
                    hdr_count[c] = CNT_PAYLOAD;
                end
            end
        end
        else
        begin
            rem = frame_len[c];
            if (rem != 0)
                rem--;
            frame_len[c] = rem;
            hdr_count[c] = (rem == 0) ? 4'd0 : CNT_PAYLOAD;
            r.payload_byte = b;
            r.message_type = hdr_type[c];
            r.message_tag = hdr_tag[c];
            r.status = ST_PAYLOAD;
            r.last = (rem == 0);
            expected_results.push_back(r);
        end
    endtask

    task automatic send_request(input logic k, input logic [7:0] c, input logic [7:0] b);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 99) < 25) ? random_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        kind <= k;
        connection <= c;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        deframe_request(k, c, b);
        requests_sent++;
    endtask

    task automatic send_header(input logic [7:0] c, input logic [15:0] t,
                               input logic [31:0] total, input logic [31:0] tag);
        logic [79:0] hdr;
        hdr = {tag, total, t};
        for (int j = 0; j < HDR_BYTES; j++)
            send_request(KIND_DATA, c, hdr[8 * j +: 8]);
    endtask

    // Drop input valid and hold until every expected result has arrived.
    task automatic wait_for_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == MAX_PAYLOAD_ADDR)
        begin
            payload_limit = value[MAX_PAYLOAD_W-1:0];
            limit_settings++;
        end
    endtask

    task automatic check_max_payload_readback();
        logic [31:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= MAX_PAYLOAD_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(payload_limit))
        begin
            $error("max_payload: expected %0d, got %0d", payload_limit, got);
            error_count++;
        end
    endtask

    task automatic set_max_payload(input logic [31:0] value);
        wait_for_quiet();
        apb_write(MAX_PAYLOAD_ADDR, value);
    endtask

    // Open a new frame on stream s, on a slot no other stream is using.
    task automatic start_stream(input int s);
        logic [7:0]  c;
        logic [15:0] t;
        logic [31:0] total;
        logic [31:0] tag;
        logic [79:0] hdr;
        int          pay;
        int          k;
        int          cap;
        bit          clash;
        do
        begin
            c = 8'($urandom_range(0, CONNECTIONS - 1));
            clash = 1'b0;
            for (int j = 0; j < STREAMS; j++)
                if (j != s && stream_slot[j] == int'(c))
                    clash = 1'b1;
        end
        while (clash);
        // flush a slot left mid-frame so the new frame starts on a header
        if (hdr_count[c] != 0)
            send_request(KIND_CLOSE, c, 8'($urandom_range(0, 255)));
        t = 16'($urandom);
        tag = $urandom;
        pay = 0;
        k = $urandom_range(0, 99);
        cap = (payload_limit < MAX_FRAME_PAYLOAD) ? int'(payload_limit) : MAX_FRAME_PAYLOAD;
        if (k < 8)
            total = $urandom_range(0, HDR_BYTES - 1);
        else if (k < 14)
            total = $urandom;
        else if (k < 20)
            total = 32'(HDR_BYTES) + 32'(payload_limit) + 1 + $urandom_range(0, 3);
        else
        begin
            pay = (k < 30 || cap == 0) ? 0 : $urandom_range(1, cap);
            total = 32'(HDR_BYTES + pay);
        end
        hdr = {tag, total, t};
        for (int j = 0; j < HDR_BYTES; j++)
            stream_buf[s][j] = hdr[8 * j +: 8];
        for (int j = 0; j < pay; j++)
            stream_buf[s][HDR_BYTES + j] = 8'($urandom_range(0, 255));
        stream_slot[s] = int'(c);
        stream_pos[s] = 0;
        stream_len[s] = HDR_BYTES + pay;
        frames_started++;
    endtask

    task automatic run_streams(input int count);
        int         r;
        int         s;
        logic [7:0] c;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, STREAMS - 1);
            if (r < 3 && stream_pos[s] < stream_len[s])
            begin
                // cut the frame short
                send_request(KIND_CLOSE, 8'(stream_slot[s]), 8'($urandom_range(0, 255)));
                stream_pos[s] = stream_len[s];
            end
            else if (r < 10)
            begin
                c = 8'($urandom_range(0, CONNECTIONS - 1));
                send_request((r < 6) ? KIND_CLOSE : KIND_DATA, c, 8'($urandom_range(0, 255)));
                for (int j = 0; j < STREAMS; j++)
                    if (stream_slot[j] == int'(c))
                        stream_pos[j] = stream_len[j];
            end
            else
            begin
                if (stream_pos[s] >= stream_len[s])
                    start_stream(s);
                send_request(KIND_DATA, 8'(stream_slot[s]), stream_buf[s][stream_pos[s]]);
                stream_pos[s]++;
            end
        end
    endtask

    task automatic test_register_access();
        check_max_payload_readback();
        // upper bits beyond the 18-bit field are dropped
        apb_write(MAX_PAYLOAD_ADDR, 32'hFFFC_0005);
        check_max_payload_readback();
        apb_write(UNUSED_ADDR, 32'h0000_3039);
        check_max_payload_readback();
        apb_write(MAX_PAYLOAD_ADDR, 32'hFFFF_FFFF);
        check_max_payload_readback();
    endtask

    task automatic test_frame_corner_cases();
        // close on a slot with no header bytes taken: no result
        send_request(KIND_CLOSE, 8'h00, 8'hFF);
        // header only, all-ones type and tag: empty message
        send_header(8'hFF, 16'hFFFF, 32'd10, 32'hFFFF_FFFF);
        // total below the header size: length error
        send_header(8'h00, 16'h0000, 32'd0, 32'h0000_0000);
        // close mid-header: drop with zero type and tag
        send_request(KIND_DATA, 8'h7E, 8'hA5);
        send_request(KIND_CLOSE, 8'h7E, 8'h00);
        // payload bytes at both extremes, then close mid-payload
        send_header(8'h81, 16'h8001, 32'd13, 32'h8000_0001);
        send_request(KIND_DATA, 8'h81, 8'hFF);
        send_request(KIND_DATA, 8'h81, 8'h00);
        send_request(KIND_CLOSE, 8'h81, 8'h5A);
    endtask

    task automatic test_full_limit_traffic();
        set_max_payload(32'(MAX_PAYLOAD_RESET));
        run_streams(100);
        // sender pause: let everything drain before resuming
        wait_for_quiet();
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        run_streams(300);
    endtask

    task automatic test_zero_limit_traffic();
        set_max_payload(32'd0);
        check_max_payload_readback();
        run_streams(150);
    endtask

    task automatic test_receiver_hold_off();
        set_max_payload(32'd12);
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        hold_off_request = 200;
        run_streams(150);
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        run_streams(150);
    endtask

    task automatic test_tight_limit_traffic();
        set_max_payload(32'd1);
        run_streams(250);
    endtask

    always
    begin : drive_out_ready
        int stall_len;
        @(negedge clk);
        if (hold_off_request != 0)
        begin
            stall_len = hold_off_request;
            hold_off_request = 0;
            out_ready <= 1'b0;
            repeat (stall_len) @(negedge clk);
        end
        else if (rx_stalls_on && $urandom_range(0, 99) < 25)
        begin
            out_ready <= 1'b0;
            repeat (random_gap() - 1) @(negedge clk);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: slot %0d status %0d", slot, status);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, slot);
                    error_count++;
                end
                if (payload_byte !== want.payload_byte)
                begin
                    $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                           payload_byte);
                    error_count++;
                end
                if (message_type !== want.message_type)
                begin
                    $error("message_type: expected %0h, got %0h", want.message_type,
                           message_type);
                    error_count++;
                end
                if (message_tag !== want.message_tag)
                begin
                    $error("message_tag: expected %0h, got %0h", want.message_tag, message_tag);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : run_tests
        for (int i = 0; i < CONNECTIONS; i++)
        begin
            hdr_count[i] = '0;
            hdr_type[i] = '0;
            hdr_tag[i] = '0;
            frame_len[i] = '0;
        end
        for (int i = 0; i < STREAMS; i++)
            stream_slot[i] = -1;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_frame_corner_cases();
        test_full_limit_traffic();
        test_zero_limit_traffic();
        test_receiver_hold_off();
        test_tight_limit_traffic();
        wait_for_quiet();

        $display("Covered %0d requests, %0d results and %0d random frames on interleaved slots,",
                 requests_sent, results_checked, frames_started);
        $display("under %0d max_payload writes, with a long receiver hold-off and sender drains.",
                 limit_settings);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
